// File: src/dssc_pkg.sv
package dssc_pkg;

  localparam int ANGLE_W    = 8;
  localparam int DUTY_W     = 13;
  localparam int PERIOD_W   = 16;
  localparam int IN_ANGLE_W = 16;
  localparam int SID_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_ANGLE_DEF = 180;

  localparam logic [ANGLE_W-1:0]  CENTER_ANGLE    = 8'd90;
  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST = 16'd15;
  localparam logic [DUTY_W-1:0]   MIN_DUTY_RST    = 13'd328;
  localparam logic [DUTY_W-1:0]   MAX_DUTY_RST    = 13'd1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY    = 2'd2;

  // servo numbers accepted on a move
  localparam logic [SID_W-1:0] SERVO_ONE = 2'd1;
  localparam logic [SID_W-1:0] SERVO_TWO = 2'd2;

  typedef enum logic {
    ACT_MOVE = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef struct packed {
    action_t                       action;
    logic [SID_W-1:0]              servo_sel;
    logic signed [IN_ANGLE_W-1:0]  angle;
    logic                          smooth;
  } in_t;

  typedef struct packed {
    logic               status;
    logic               update_one;
    logic [DUTY_W-1:0]  duty_one;
    logic               update_two;
    logic [DUTY_W-1:0]  duty_two;
    logic [ANGLE_W-1:0] pos_one;
    logic [ANGLE_W-1:0] pos_two;
    logic               busy_one;
    logic               busy_two;
  } out_t;

  // everything of a result except the duties
  typedef struct packed {
    logic               status;
    logic               update_one;
    logic               update_two;
    logic [ANGLE_W-1:0] pos_one;
    logic [ANGLE_W-1:0] pos_two;
    logic               busy_one;
    logic               busy_two;
  } flags_t;

endpackage

// File: src/dual_servo_slew_controller_core.sv
// Two-channel servo position controller with slew limiting.
//
// Input channel (item / item_valid / item_stall): a move sets a servo's
// angle, either at once or as a target reached one degree per step; a tick
// counts toward the step period. Output channel (result / result_valid /
// result_stall): one result per item with status, per-servo duty, angle,
// busy flag and a flag for each duty that the item rewrote.
// Configuration is written through wr_en / wr_index / wr_data; the user must
// write it only while no transaction is in flight; the block does not enforce it.
//
// Throughput: one item per cycle while result_stall does not hold the
// output. Each result passes the registers v1, v2 and result_valid, in
// step with the duty pipeline (angle times span, reciprocal multiply for the
// division by the angle range, offset and saturate).
// The servo state itself is updated in the acceptance cycle.
//
// A stalled result holds the whole pipeline; item_stall rises in the same
// cycle. Reset returns both servos to 90 degrees, idle, clears the tick
// count, loads the default registers and empties the pipeline.
module dual_servo_slew_controller_core #(
  parameter int MaxAngle = dssc_pkg::MAX_ANGLE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  dssc_pkg::in_t                     item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output dssc_pkg::out_t                    result,
  input  logic                              wr_en,
  input  logic [dssc_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [dssc_pkg::CFG_DATA_W-1:0]   wr_data
);

  logic [dssc_pkg::PERIOD_W-1:0] step_period;
  logic [dssc_pkg::DUTY_W-1:0]   min_duty;
  logic [dssc_pkg::DUTY_W-1:0]   max_duty;

  logic             adv;
  logic             accept;
  logic             v1, v2;
  dssc_pkg::flags_t flags, f1, f2, f3;
  logic [dssc_pkg::DUTY_W-1:0] duty_one, duty_two;

  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;
  assign accept     = item_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= dssc_pkg::STEP_PERIOD_RST;
      min_duty    <= dssc_pkg::MIN_DUTY_RST;
      max_duty    <= dssc_pkg::MAX_DUTY_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        dssc_pkg::REG_STEP_PERIOD: step_period <= wr_data[dssc_pkg::PERIOD_W-1:0];
        dssc_pkg::REG_MIN_DUTY:    min_duty    <= wr_data[dssc_pkg::DUTY_W-1:0];
        dssc_pkg::REG_MAX_DUTY:    max_duty    <= wr_data[dssc_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  dssc_state #(.MaxAngle(MaxAngle)) u_state (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .step_period (step_period),
    .flags       (flags)
  );

  dssc_duty #(.MaxAngle(MaxAngle)) u_duty_one (
    .clk      (clk),
    .adv      (adv),
    .angle    (flags.pos_one),
    .min_duty (min_duty),
    .max_duty (max_duty),
    .duty     (duty_one)
  );

  dssc_duty #(.MaxAngle(MaxAngle)) u_duty_two (
    .clk      (clk),
    .adv      (adv),
    .angle    (flags.pos_two),
    .min_duty (min_duty),
    .max_duty (max_duty),
    .duty     (duty_two)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      v1           <= accept;
      v2           <= v1;
      result_valid <= v2;
    end
  end

  // flags ride alongside the duty pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      f1 <= flags;
      f2 <= f1;
      f3 <= f2;
    end
  end

  always_comb begin
    result.status     = f3.status;
    result.update_one = f3.update_one;
    result.duty_one   = duty_one;
    result.update_two = f3.update_two;
    result.duty_two   = duty_two;
    result.pos_one    = f3.pos_one;
    result.pos_two    = f3.pos_two;
    result.busy_one   = f3.busy_one;
    result.busy_two   = f3.busy_two;
  end

  a_status_no_update: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status |-> !result.update_one && !result.update_two)
    else $error("rejected move reports a duty update");

  a_bad_servo_status: assert property (@(posedge clk) disable iff (rst)
    accept && item.action == dssc_pkg::ACT_MOVE &&
    item.servo_sel != dssc_pkg::SERVO_ONE && item.servo_sel != dssc_pkg::SERVO_TWO
    |=> v1 && f1.status)
    else $error("invalid servo number not flagged");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !v1 && !v2 && !result_valid)
    else $error("pipeline not empty after reset");

endmodule

// File: src/dssc_state.sv
module dssc_state #(
  parameter int MaxAngle = dssc_pkg::MAX_ANGLE_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  dssc_pkg::in_t                   item,
  input  logic [dssc_pkg::PERIOD_W-1:0]   step_period,
  output dssc_pkg::flags_t                flags
);

  localparam logic [dssc_pkg::IN_ANGLE_W-1:0] MAX_IN  = dssc_pkg::IN_ANGLE_W'(MaxAngle);
  localparam logic [dssc_pkg::ANGLE_W-1:0]    MAX_POS = dssc_pkg::ANGLE_W'(MaxAngle);

  logic [1:0][dssc_pkg::ANGLE_W-1:0] cur, cur_next;
  logic [1:0][dssc_pkg::ANGLE_W-1:0] tgt, tgt_next;
  logic [1:0]                        slewing, slewing_next;
  logic [dssc_pkg::PERIOD_W-1:0]     elapsed, elapsed_next;

  logic [dssc_pkg::PERIOD_W-1:0] elapsed_inc;
  logic [dssc_pkg::ANGLE_W-1:0]  clamp;
  logic [1:0]                    chan_hit;
  logic [1:0]                    upd;
  logic                          step;
  logic                          is_move;

  always_comb begin
    is_move     = (item.action == dssc_pkg::ACT_MOVE);
    chan_hit[0] = (item.servo_sel == dssc_pkg::SERVO_ONE);
    chan_hit[1] = (item.servo_sel == dssc_pkg::SERVO_TWO);

    if (item.angle[dssc_pkg::IN_ANGLE_W-1]) begin
      clamp = '0;
    end else if ($unsigned(item.angle) > MAX_IN) begin
      clamp = MAX_POS;
    end else begin
      clamp = item.angle[dssc_pkg::ANGLE_W-1:0];
    end

    // saturating tick count
    elapsed_inc = (elapsed == '1) ? elapsed : elapsed + 1'b1;
    step        = (elapsed_inc >= step_period);

    elapsed_next = elapsed;
    if (!is_move) begin
      elapsed_next = step ? '0 : elapsed_inc;
    end

    cur_next     = cur;
    tgt_next     = tgt;
    slewing_next = slewing;
    upd          = '0;

    for (int c = 0; c < 2; c++) begin
      if (is_move) begin
        if (chan_hit[c]) begin
          tgt_next[c] = clamp;
          if (item.smooth) begin
            slewing_next[c] = (cur[c] != clamp);
          end else begin
            cur_next[c]     = clamp;
            slewing_next[c] = 1'b0;
            upd[c]          = 1'b1;
          end
        end
      end else if (step && slewing[c]) begin
        if (cur[c] == tgt[c]) begin
          slewing_next[c] = 1'b0;
        end else begin
          cur_next[c]     = (tgt[c] > cur[c]) ? cur[c] + 1'b1 : cur[c] - 1'b1;
          slewing_next[c] = (cur_next[c] != tgt[c]);
          upd[c]          = 1'b1;
        end
      end
    end

    flags.status     = is_move && !chan_hit[0] && !chan_hit[1];
    flags.update_one = upd[0];
    flags.update_two = upd[1];
    flags.pos_one    = cur_next[0];
    flags.pos_two    = cur_next[1];
    flags.busy_one   = slewing_next[0];
    flags.busy_two   = slewing_next[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur     <= {dssc_pkg::CENTER_ANGLE, dssc_pkg::CENTER_ANGLE};
      tgt     <= {dssc_pkg::CENTER_ANGLE, dssc_pkg::CENTER_ANGLE};
      slewing <= '0;
      elapsed <= '0;
    end else if (accept) begin
      cur     <= cur_next;
      tgt     <= tgt_next;
      slewing <= slewing_next;
      elapsed <= elapsed_next;
    end
  end

endmodule

// File: src/dssc_duty.sv
module dssc_duty #(
  parameter int MaxAngle = dssc_pkg::MAX_ANGLE_DEF
) (
  input  logic                          clk,
  input  logic                          adv,
  input  logic [dssc_pkg::ANGLE_W-1:0]  angle,
  input  logic [dssc_pkg::DUTY_W-1:0]   min_duty,
  input  logic [dssc_pkg::DUTY_W-1:0]   max_duty,
  output logic [dssc_pkg::DUTY_W-1:0]   duty
);

  localparam int PROD_W  = dssc_pkg::ANGLE_W + dssc_pkg::DUTY_W;
  // exact floor division by MaxAngle for any product below 2**PROD_W
  localparam int SHIFT   = PROD_W + $clog2(MaxAngle);
  localparam int RECIP_W = PROD_W + 2;
  localparam int FULL_W  = SHIFT + PROD_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + longint'(MaxAngle) - 64'd1) / longint'(MaxAngle);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  logic signed [dssc_pkg::DUTY_W:0] span;
  logic                             neg;
  logic [dssc_pkg::DUTY_W-1:0]      mag;
  logic [FULL_W-1:0]                full;
  logic signed [SUM_W-1:0]          sum;

  logic [PROD_W-1:0] prod1;
  logic              neg1;
  logic [PROD_W-1:0] quo2;
  logic              neg2;

  always_comb begin
    span = $signed({1'b0, max_duty}) - $signed({1'b0, min_duty});
    neg  = span[dssc_pkg::DUTY_W];
    mag  = neg ? dssc_pkg::DUTY_W'(-span) : span[dssc_pkg::DUTY_W-1:0];
    full = FULL_W'(prod1) * FULL_W'(RECIP);
    sum  = neg2 ? $signed(SUM_W'(min_duty)) - $signed(SUM_W'(quo2))
                : $signed(SUM_W'(min_duty)) + $signed(SUM_W'(quo2));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod1 <= PROD_W'(angle) * PROD_W'(mag);
      neg1  <= neg;
      quo2  <= full[SHIFT +: PROD_W];
      neg2  <= neg1;
      if (sum[SUM_W-1]) begin
        duty <= '0;
      end else if (sum[SUM_W-2:dssc_pkg::DUTY_W] != '0) begin
        duty <= '1;
      end else begin
        duty <= sum[dssc_pkg::DUTY_W-1:0];
      end
    end
  end

endmodule
